// ===== sv/rrib_pkg.sv =====
// ----------------------------------------------------------------------------
// rrib_pkg
// Shared types and constants for the rotated rectangle invert blitter.
// ----------------------------------------------------------------------------
package rrib_pkg;

    // command codes carried in s_tuser
    localparam logic [1:0] OP_INVERT = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_ROTATION   = 2'd0;
    localparam logic [1:0] REG_MEM_WIDTH  = 2'd1;
    localparam logic [1:0] REG_MEM_HEIGHT = 2'd2;
    localparam logic [1:0] REG_ROW_BYTES  = 2'd3;

    // leftmost pixel of a byte sits in the msb
    localparam logic [7:0] PIXEL_MSB = 8'h80;

    // saturation level of the toggle counter
    localparam logic [17:0] COUNT_MAX = 18'h3FFFF;

    // byte offsets are formed this wide before the range check
    localparam int unsigned ADDR_EXT_W = 17;

    // display geometry seen by the pixel unit
    typedef struct packed {
        logic [1:0] rotation;
        logic [8:0] mem_width;
        logic [9:0] mem_height;
        logic [5:0] row_bytes;
    } geom_t;

    // stage enables for the pixel unit
    typedef struct packed {
        logic map_en;
        logic addr_en;
    } pix_ctl_t;

    // pixel unit result: byte offset, bit mask and whether it lands in memory
    typedef struct packed {
        logic                  hit;
        logic [7:0]            mask;
        logic [ADDR_EXT_W-1:0] addr;
    } pix_res_t;

endpackage

// ===== sv/rrib_frame_mem.sv =====
// ----------------------------------------------------------------------------
// rrib_frame_mem
// Single-port frame store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module rrib_frame_mem #(
    parameter int unsigned DEPTH = 16384,
    parameter int unsigned AW    = 14
) (
    input  logic          aclk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] store_mem [DEPTH];
    logic [7:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= store_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/rrib_pix_unit.sv =====
// ----------------------------------------------------------------------------
// rrib_pix_unit
// Shared pixel unit: maps a display pixel through the rotation, then forms
// the byte offset and bit mask in a second registered stage.
// ----------------------------------------------------------------------------
module rrib_pix_unit #(
    parameter int unsigned FB_BYTES = 16384
) (
    input  logic              aclk,
    input  rrib_pkg::pix_ctl_t ctl,
    input  rrib_pkg::geom_t    geom,
    input  logic [9:0]        xd,
    input  logic [9:0]        yd,
    output rrib_pkg::pix_res_t res
);

    localparam logic [rrib_pkg::ADDR_EXT_W-1:0] FB_LIMIT =
        rrib_pkg::ADDR_EXT_W'(FB_BYTES);

    logic signed [11:0] xd_s;
    logic signed [11:0] yd_s;
    logic signed [11:0] w_s;
    logic signed [11:0] h_s;
    logic signed [11:0] xm;
    logic signed [11:0] ym;
    logic               inb;

    logic [8:0] xm_reg;
    logic [9:0] ym_reg;
    logic       inb_reg;

    logic [15:0]                      prod;
    logic [rrib_pkg::ADDR_EXT_W-1:0]  sum;

    logic                             hit_reg;
    logic [7:0]                       mask_reg;
    logic [rrib_pkg::ADDR_EXT_W-1:0]  addr_reg;

    // rotation map to memory coordinates
    always_comb begin
        xd_s = signed'({2'b00, xd});
        yd_s = signed'({2'b00, yd});
        w_s  = signed'({3'b000, geom.mem_width});
        h_s  = signed'({2'b00, geom.mem_height});
        case (geom.rotation)
            rrib_pkg::ROT_0: begin
                xm = yd_s;
                ym = xd_s;
            end
            rrib_pkg::ROT_90: begin
                xm = xd_s;
                ym = h_s - yd_s - 12'sd1;
            end
            rrib_pkg::ROT_180: begin
                xm = w_s - yd_s - 12'sd1;
                ym = h_s - xd_s - 12'sd1;
            end
            default: begin
                xm = w_s - xd_s - 12'sd1;
                ym = yd_s;
            end
        endcase
        inb = (xm >= 12'sd0) && (ym >= 12'sd0) && (xm < w_s) && (ym < h_s);
    end

    // stage one: mapped coordinates
    always_ff @(posedge aclk) begin
        if (ctl.map_en) begin
            xm_reg  <= xm[8:0];
            ym_reg  <= ym[9:0];
            inb_reg <= inb;
        end
    end

    // byte offset: column byte plus row times row pitch
    always_comb begin
        prod = {6'd0, ym_reg} * {10'd0, geom.row_bytes};
        sum  = rrib_pkg::ADDR_EXT_W'(prod) + rrib_pkg::ADDR_EXT_W'(xm_reg[8:3]);
    end

    // stage two: offset, range check and mask
    always_ff @(posedge aclk) begin
        if (ctl.addr_en) begin
            addr_reg <= sum;
            hit_reg  <= inb_reg && (sum < FB_LIMIT);
            mask_reg <= rrib_pkg::PIXEL_MSB >> xm_reg[2:0];
        end
    end

    assign res.hit  = hit_reg;
    assign res.mask = mask_reg;
    assign res.addr = addr_reg;

endmodule

// ===== sv/rotated_rect_invert_blitter.sv =====
// ----------------------------------------------------------------------------
// rotated_rect_invert_blitter
// 1 bpp frame store with byte access and a clipped, rotated rectangle invert.
// ----------------------------------------------------------------------------
// One command is worked on at a time; s_tready is high only while the
// sequencer is idle, and the next command is taken while the previous
// result still waits in the output register. A byte write goes straight
// to the done state; a byte read first waits for the data, since the
// frame store has a single port with registered read data. An empty or
// fully clipped invert also goes straight to the done state; any other
// invert walks its pixels in raster order: every pixel goes through the
// shared pixel unit (rotation map, then offset and mask), and a toggled
// one also through a read-modify-write on the single store port, while a
// pixel dropped because it falls off the memory or its byte lies past
// the end of the store is not touched. A finished command holds in its
// done state, with s_tready low, for as long as the output register
// still holds an untaken result. The frame store is not cleared; reading
// or inverting a byte before it was written returns undefined data.
module rotated_rect_invert_blitter #(
    parameter int unsigned FB_BYTES   = 16384,
    parameter int unsigned MAX_WIDTH  = 256,
    parameter int unsigned MAX_HEIGHT = 512
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    // rect_x[8:0], rect_y[17:9], rect_w[27:18], rect_h[37:28],
    // byte_addr[51:38], write_byte[59:52], zero fill
    input  logic [63:0] s_tdata,
    // op[1:0]
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // read_byte[7:0], toggled_count[25:8], no_effect[26], zero fill
    output logic [31:0] m_tdata
);

    localparam int unsigned AW = $clog2(FB_BYTES);
    localparam int unsigned WIDTH_CAP  = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
    localparam int unsigned HEIGHT_CAP = (MAX_HEIGHT > 1023) ? 1023 : MAX_HEIGHT;
    localparam logic [rrib_pkg::ADDR_EXT_W-1:0] FB_LIMIT =
        rrib_pkg::ADDR_EXT_W'(FB_BYTES);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MAP     = 3'd1;
    localparam logic [2:0] ST_ADDR    = 3'd2;
    localparam logic [2:0] ST_RMW_RD  = 3'd3;
    localparam logic [2:0] ST_RMW_WR  = 3'd4;
    localparam logic [2:0] ST_RD_WAIT = 3'd5;
    localparam logic [2:0] ST_DONE    = 3'd6;

    // configuration registers
    logic [1:0] rotation_reg,   rotation_next;
    logic [8:0] mem_width_reg,  mem_width_next;
    logic [9:0] mem_height_reg, mem_height_next;
    logic [5:0] row_bytes_reg,  row_bytes_next;

    // sequencer state
    logic [2:0]  state_reg,     state_next;
    logic [9:0]  x0_reg,        x0_next;
    logic [9:0]  xe_reg,        xe_next;
    logic [9:0]  ye_reg,        ye_next;
    logic [9:0]  xd_reg,        xd_next;
    logic [9:0]  yd_reg,        yd_next;
    logic        rd_hit_reg,    rd_hit_next;
    logic [7:0]  read_byte_reg, read_byte_next;
    logic [17:0] count_reg,     count_next;
    logic        no_effect_reg, no_effect_next;
    logic        m_tvalid_reg,  m_tvalid_next;
    logic [31:0] m_tdata_reg,   m_tdata_next;

    // input fields
    logic [1:0]  in_op;
    logic [8:0]  in_x;
    logic [8:0]  in_y;
    logic [9:0]  in_w;
    logic [9:0]  in_h;
    logic [13:0] in_addr;
    logic [7:0]  in_byte;
    logic        in_xfer;

    // clip and step logic
    logic        wide_rot;
    logic [9:0]  dmx;
    logic [9:0]  dmy;
    logic [10:0] sum_x;
    logic [10:0] sum_y;
    logic [9:0]  xe_c;
    logic [9:0]  ye_c;
    logic        empty_c;
    logic [9:0]  xd_inc;
    logic [9:0]  yd_inc;
    logic        x_wrap;
    logic        last_pix;

    logic [rrib_pkg::ADDR_EXT_W-1:0] ba_ext;
    logic                            ba_ok;

    // store port and pixel unit
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;

    rrib_pkg::geom_t    geom;
    rrib_pkg::pix_ctl_t pix_ctl;
    rrib_pkg::pix_res_t pix_res;

    // unpack the input transfer
    assign in_op   = s_tuser;
    assign in_x    = s_tdata[8:0];
    assign in_y    = s_tdata[17:9];
    assign in_w    = s_tdata[27:18];
    assign in_h    = s_tdata[37:28];
    assign in_addr = s_tdata[51:38];
    assign in_byte = s_tdata[59:52];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    assign geom.rotation   = rotation_reg;
    assign geom.mem_width  = mem_width_reg;
    assign geom.mem_height = mem_height_reg;
    assign geom.row_bytes  = row_bytes_reg;

    // configuration writes, sizes saturate at the build limits
    always_comb begin
        rotation_next   = rotation_reg;
        mem_width_next  = mem_width_reg;
        mem_height_next = mem_height_reg;
        row_bytes_next  = row_bytes_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                rrib_pkg::REG_ROTATION: begin
                    rotation_next = cfg_wdata[1:0];
                end
                rrib_pkg::REG_MEM_WIDTH: begin
                    if (32'(cfg_wdata[8:0]) > WIDTH_CAP) begin
                        mem_width_next = 9'(WIDTH_CAP);
                    end else begin
                        mem_width_next = cfg_wdata[8:0];
                    end
                end
                rrib_pkg::REG_MEM_HEIGHT: begin
                    if (32'(cfg_wdata) > HEIGHT_CAP) begin
                        mem_height_next = 10'(HEIGHT_CAP);
                    end else begin
                        mem_height_next = cfg_wdata;
                    end
                end
                rrib_pkg::REG_ROW_BYTES: begin
                    row_bytes_next = cfg_wdata[5:0];
                end
                default: begin
                    rotation_next = rotation_reg;
                end
            endcase
        end
    end

    // clip the rectangle to the display extent
    always_comb begin
        wide_rot = (rotation_reg == rrib_pkg::ROT_0) ||
                   (rotation_reg == rrib_pkg::ROT_180);
        dmx      = wide_rot ? mem_height_reg : {1'b0, mem_width_reg};
        dmy      = wide_rot ? {1'b0, mem_width_reg} : mem_height_reg;
        sum_x    = {2'b00, in_x} + {1'b0, in_w};
        sum_y    = {2'b00, in_y} + {1'b0, in_h};
        xe_c     = (sum_x > {1'b0, dmx}) ? dmx : sum_x[9:0];
        ye_c     = (sum_y > {1'b0, dmy}) ? dmy : sum_y[9:0];
        empty_c  = (in_w == 10'd0) || (in_h == 10'd0) ||
                   ({1'b0, in_x} >= xe_c) || ({1'b0, in_y} >= ye_c) ||
                   (row_bytes_reg == 6'd0);
        ba_ext   = rrib_pkg::ADDR_EXT_W'(in_addr);
        ba_ok    = ba_ext < FB_LIMIT;
    end

    // raster walk: next pixel and end of rectangle
    always_comb begin
        xd_inc   = xd_reg + 10'd1;
        yd_inc   = yd_reg + 10'd1;
        x_wrap   = (xd_inc == xe_reg);
        last_pix = x_wrap && (yd_inc == ye_reg);
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        x0_next        = x0_reg;
        xe_next        = xe_reg;
        ye_next        = ye_reg;
        xd_next        = xd_reg;
        yd_next        = yd_reg;
        rd_hit_next    = rd_hit_reg;
        read_byte_next = read_byte_reg;
        count_next     = count_reg;
        no_effect_next = no_effect_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = pix_res.addr[AW-1:0];
        mem_wdata      = mem_rdata ^ pix_res.mask;
        pix_ctl.map_en  = 1'b0;
        pix_ctl.addr_en = 1'b0;

        // result taken downstream
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                mem_addr = ba_ext[AW-1:0];
                if (in_xfer) begin
                    read_byte_next = 8'd0;
                    count_next     = 18'd0;
                    no_effect_next = 1'b0;
                    case (in_op)
                        rrib_pkg::OP_INVERT: begin
                            no_effect_next = empty_c;
                            x0_next        = {1'b0, in_x};
                            xd_next        = {1'b0, in_x};
                            yd_next        = {1'b0, in_y};
                            xe_next        = xe_c;
                            ye_next        = ye_c;
                            state_next     = empty_c ? ST_DONE : ST_MAP;
                        end
                        rrib_pkg::OP_WRITE: begin
                            mem_we     = ba_ok;
                            mem_wdata  = in_byte;
                            state_next = ST_DONE;
                        end
                        rrib_pkg::OP_READ: begin
                            mem_re      = ba_ok;
                            rd_hit_next = ba_ok;
                            state_next  = ST_RD_WAIT;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MAP: begin
                pix_ctl.map_en = 1'b1;
                state_next     = ST_ADDR;
            end
            ST_ADDR: begin
                pix_ctl.addr_en = 1'b1;
                state_next      = ST_RMW_RD;
            end
            ST_RMW_RD: begin
                if (pix_res.hit) begin
                    mem_re     = 1'b1;
                    state_next = ST_RMW_WR;
                end else if (last_pix) begin
                    state_next = ST_DONE;
                end else begin
                    xd_next    = x_wrap ? x0_reg : xd_inc;
                    yd_next    = x_wrap ? yd_inc : yd_reg;
                    state_next = ST_MAP;
                end
            end
            ST_RMW_WR: begin
                mem_we = 1'b1;
                if (count_reg != rrib_pkg::COUNT_MAX) begin
                    count_next = count_reg + 18'd1;
                end
                if (last_pix) begin
                    state_next = ST_DONE;
                end else begin
                    xd_next    = x_wrap ? x0_reg : xd_inc;
                    yd_next    = x_wrap ? yd_inc : yd_reg;
                    state_next = ST_MAP;
                end
            end
            ST_RD_WAIT: begin
                read_byte_next = rd_hit_reg ? mem_rdata : 8'd0;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, no_effect_reg, count_reg, read_byte_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotation_reg   <= rrib_pkg::ROT_0;
            mem_width_reg  <= 9'd128;
            mem_height_reg <= 10'd296;
            row_bytes_reg  <= 6'd16;
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
        end else begin
            rotation_reg   <= rotation_next;
            mem_width_reg  <= mem_width_next;
            mem_height_reg <= mem_height_next;
            row_bytes_reg  <= row_bytes_next;
            state_reg      <= state_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        x0_reg        <= x0_next;
        xe_reg        <= xe_next;
        ye_reg        <= ye_next;
        xd_reg        <= xd_next;
        yd_reg        <= yd_next;
        rd_hit_reg    <= rd_hit_next;
        read_byte_reg <= read_byte_next;
        count_reg     <= count_next;
        no_effect_reg <= no_effect_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    rrib_pix_unit #(
        .FB_BYTES (FB_BYTES)
    ) u_pix_unit (
        .aclk (aclk),
        .ctl  (pix_ctl),
        .geom (geom),
        .xd   (xd_reg),
        .yd   (yd_reg),
        .res  (pix_res)
    );

    rrib_frame_mem #(
        .DEPTH (FB_BYTES),
        .AW    (AW)
    ) u_frame_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // the single store port never reads and writes in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("frame store read and write in the same cycle");

    // the sequencer only leaves idle on an input transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) && !in_xfer |=> (state_reg == ST_IDLE))
        else $error("sequencer left idle without an input transfer");

    // a new result only appears when a command finishes
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result presented without a finished command");

    // every toggled pixel is counted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RMW_WR) |=> (count_reg != 18'd0))
        else $error("pixel toggled but count still zero");

endmodule

// ===== dv/blit_monitor.sv =====
// ----------------------------------------------------------------------------
// blit_monitor
// Watches the configuration port and both stream channels of the blitter,
// keeps its own copy of the frame store and geometry, works out the result
// of every accepted command and compares it field by field with what the
// block returns. Failures are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module blit_monitor #(
    parameter int unsigned FB_BYTES   = 16384,
    parameter int unsigned MAX_WIDTH  = 256,
    parameter int unsigned MAX_HEIGHT = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // one result transfer, laid out as in m_tdata
    typedef struct packed {
        logic        no_effect;
        logic [17:0] toggled_count;
        logic [7:0]  read_byte;
    } blit_result_t;

    // geometry as the block should hold it, saturation applied
    logic [1:0] geo_rot;
    int         geo_width;
    int         geo_height;
    int         geo_row_bytes;

    logic [7:0]   frame_bytes [FB_BYTES];
    blit_result_t expected_q [$];
    blit_result_t want;
    blit_result_t got;

    // result of one command; updates the frame store copy on the way
    function automatic blit_result_t blit_command(input logic [1:0] op,
                                                  input logic [63:0] d);
        blit_result_t res;
        int rx, ry, rw, rh, addr, dmx, dmy, xe, ye, xm, ym, pix_addr, cnt;
        res  = '0;
        rx   = d[8:0];
        ry   = d[17:9];
        rw   = d[27:18];
        rh   = d[37:28];
        addr = d[51:38];
        case (op)
            rrib_pkg::OP_INVERT: begin
                res.no_effect = 1'b1;
                if (geo_rot == rrib_pkg::ROT_0 || geo_rot == rrib_pkg::ROT_180) begin
                    dmx = geo_height;
                    dmy = geo_width;
                end else begin
                    dmx = geo_width;
                    dmy = geo_height;
                end
                // clip against the display extent, sums taken wide
                xe = (rx + rw > dmx) ? dmx : rx + rw;
                ye = (ry + rh > dmy) ? dmy : ry + rh;
                if (rw != 0 && rh != 0 && rx < xe && ry < ye &&
                    geo_row_bytes != 0) begin
                    res.no_effect = 1'b0;
                    cnt = 0;
                    for (int yd = ry; yd < ye; yd++) begin
                        for (int xd = rx; xd < xe; xd++) begin
                            case (geo_rot)
                                rrib_pkg::ROT_0: begin
                                    xm = yd;
                                    ym = xd;
                                end
                                rrib_pkg::ROT_90: begin
                                    xm = xd;
                                    ym = geo_height - yd - 1;
                                end
                                rrib_pkg::ROT_180: begin
                                    xm = geo_width - yd - 1;
                                    ym = geo_height - xd - 1;
                                end
                                default: begin
                                    xm = geo_width - xd - 1;
                                    ym = yd;
                                end
                            endcase
                            // pixels off the memory or past the store are dropped
                            if (xm >= 0 && ym >= 0 && xm < geo_width &&
                                ym < geo_height) begin
                                pix_addr = xm / 8 + ym * geo_row_bytes;
                                if (pix_addr < FB_BYTES) begin
                                    frame_bytes[pix_addr] ^= rrib_pkg::PIXEL_MSB >> (xm % 8);
                                    if (cnt < rrib_pkg::COUNT_MAX)
                                        cnt++;
                                end
                            end
                        end
                    end
                    res.toggled_count = cnt[17:0];
                end
            end
            rrib_pkg::OP_WRITE: begin
                if (addr < FB_BYTES)
                    frame_bytes[addr] = d[59:52];
            end
            rrib_pkg::OP_READ: begin
                if (addr < FB_BYTES)
                    res.read_byte = frame_bytes[addr];
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < 10)
            $display("%0t ns: %s", $realtime, msg);
        fail_count++;
    endtask

    // configuration, command and result transfers
    always @(posedge aclk) begin
        if (!aresetn) begin
            geo_rot       = rrib_pkg::ROT_0;
            geo_width     = 128;
            geo_height    = 296;
            geo_row_bytes = 16;
            expected_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    rrib_pkg::REG_ROTATION:   geo_rot = cfg_wdata[1:0];
                    rrib_pkg::REG_MEM_WIDTH:
                        geo_width = (cfg_wdata[8:0] > MAX_WIDTH) ? MAX_WIDTH
                                                                 : cfg_wdata[8:0];
                    rrib_pkg::REG_MEM_HEIGHT:
                        geo_height = (cfg_wdata > MAX_HEIGHT) ? MAX_HEIGHT : cfg_wdata;
                    default:                  geo_row_bytes = cfg_wdata[5:0];
                endcase
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(blit_command(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata[26:0];
                if (expected_q.size() == 0) begin
                    note_failure($sformatf(
                        "result with none expected: read_byte %0d, count %0d, no_effect %0d",
                        got.read_byte, got.toggled_count, got.no_effect));
                end else begin
                    want = expected_q.pop_front();
                    if (got.read_byte != want.read_byte)
                        note_failure($sformatf("read_byte: expected %0d, got %0d",
                                               want.read_byte, got.read_byte));
                    if (got.toggled_count != want.toggled_count)
                        note_failure($sformatf("toggled_count: expected %0d, got %0d",
                                               want.toggled_count, got.toggled_count));
                    if (got.no_effect != want.no_effect)
                        note_failure($sformatf("no_effect: expected %0d, got %0d",
                                               want.no_effect, got.no_effect));
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the rotated rectangle invert blitter with byte writes, byte reads
// and clipped rectangle inverts over a range of rotations and memory shapes.
// Every byte that a read or an invert can reach is written first. Both
// stream sides stall at random; the monitor checks every result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FB_BYTES   = 16384;
    localparam int unsigned MAX_WIDTH  = 256;
    localparam int unsigned MAX_HEIGHT = 512;
    localparam int          ITEMS      = 1170;
    localparam int          PHASES     = 12;

    // command code the block leaves unused
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = rrib_pkg::REG_ROTATION;
    logic [9:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = rrib_pkg::OP_INVERT;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    int          fail_count;
    int          pending;

    // stall rates in percent and the count of long receiver hold-off requests
    int send_idle     = 15;
    int recv_idle     = 49;
    int hold_requests = 0;

    // geometry last written, as the block holds it
    logic [1:0] g_rot    = rrib_pkg::ROT_0;
    int         g_width  = 128;
    int         g_height = 296;
    int         g_rb     = 16;

    // bytes of the frame store already written
    bit written [FB_BYTES];
    int written_addrs [$];
    int items_sent = 0;

    // geometry sequence for the first phases; the rest are random
    logic [1:0] phase_rot [8] = '{rrib_pkg::ROT_0, rrib_pkg::ROT_90,
                                  rrib_pkg::ROT_180, rrib_pkg::ROT_270,
                                  rrib_pkg::ROT_90, rrib_pkg::ROT_0,
                                  rrib_pkg::ROT_180, rrib_pkg::ROT_270};
    int phase_width  [8] = '{16, 40, 511, 0, 8, 24, 20, 64};
    int phase_height [8] = '{24, 20, 1023, 100, 512, 16, 30, 40};
    int phase_rb     [8] = '{2, 5, 32, 4, 63, 0, 3, 8};

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    rotated_rect_invert_blitter #(
        .FB_BYTES  (FB_BYTES),
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    blit_monitor #(
        .FB_BYTES  (FB_BYTES),
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) mon (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // one command transfer; entered and left at a falling edge
    task automatic send_cmd(input logic [1:0] op, input int x, input int y, input int w,
                            input int h, input int addr, input int wb);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, wb[7:0], addr[13:0], h[9:0], w[9:0], y[8:0], x[8:0]};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (op == rrib_pkg::OP_WRITE && !written[addr]) begin
            written[addr] = 1'b1;
            written_addrs.push_back(addr);
        end
        items_sent++;
    endtask

    // hold the input low until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [9:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    // all four registers, unused upper bits random
    task automatic set_geometry(input logic [1:0] rot, input int w, input int h, input int rb);
        drain();
        cfg_write(rrib_pkg::REG_ROTATION, {8'($urandom_range(0, 255)), rot});
        cfg_write(rrib_pkg::REG_MEM_WIDTH, {1'($urandom_range(0, 1)), w[8:0]});
        cfg_write(rrib_pkg::REG_MEM_HEIGHT, h[9:0]);
        cfg_write(rrib_pkg::REG_ROW_BYTES, {4'($urandom_range(0, 15)), rb[5:0]});
        cfg_wr_en <= 1'b0;
        g_rot    = rot;
        g_width  = (w[8:0] > MAX_WIDTH) ? MAX_WIDTH : w[8:0];
        g_height = (h[9:0] > MAX_HEIGHT) ? MAX_HEIGHT : h[9:0];
        g_rb     = rb[5:0];
    endtask

    // invert, after writing every store byte the rectangle can reach
    task automatic rect_invert(input int x, input int y, input int w, input int h);
        int dx, dy, xe, ye, xlo, xhi, ylo, yhi, a;
        dx = (g_rot == rrib_pkg::ROT_0 || g_rot == rrib_pkg::ROT_180) ? g_height : g_width;
        dy = (g_rot == rrib_pkg::ROT_0 || g_rot == rrib_pkg::ROT_180) ? g_width : g_height;
        xe = (x + w > dx) ? dx : x + w;
        ye = (y + h > dy) ? dy : y + h;
        if (x < xe && y < ye && g_rb != 0) begin
            // bounding box of the clipped rectangle in memory coordinates
            case (g_rot)
                rrib_pkg::ROT_0: begin
                    xlo = y;            xhi = ye - 1;
                    ylo = x;            yhi = xe - 1;
                end
                rrib_pkg::ROT_90: begin
                    xlo = x;            xhi = xe - 1;
                    ylo = g_height - ye; yhi = g_height - y - 1;
                end
                rrib_pkg::ROT_180: begin
                    xlo = g_width - ye;  xhi = g_width - y - 1;
                    ylo = g_height - xe; yhi = g_height - x - 1;
                end
                default: begin
                    xlo = g_width - xe;  xhi = g_width - x - 1;
                    ylo = y;            yhi = ye - 1;
                end
            endcase
            for (int ym = ylo; ym <= yhi; ym++) begin
                for (int b = xlo / 8; b <= xhi / 8; b++) begin
                    a = b + ym * g_rb;
                    if (a < FB_BYTES && !written[a])
                        send_cmd(rrib_pkg::OP_WRITE, $urandom_range(0, 511),
                                 $urandom_range(0, 511), $urandom_range(0, 1023),
                                 $urandom_range(0, 1023), a, $urandom_range(0, 255));
                end
            end
        end
        send_cmd(rrib_pkg::OP_INVERT, x, y, w, h, $urandom_range(0, FB_BYTES - 1),
                 $urandom_range(0, 255));
    endtask

    // receiver stalls, with one long hold-off per request
    initial begin : receiver
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        forever begin
            @(negedge aclk);
            if (hold_requests != holds_seen) begin
                holds_seen = hold_requests;
                hold_left  = 300;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    initial begin
        #50ms;
        $display("status: fail");
        $finish;
    end

    // stimulus and verdict
    initial begin : stimulus
        int base, phase_end, pick, r, x, y, w, h, dx, dy;
        bit big_ok;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: field extremes, every command, empty and clipped inverts
        send_cmd(rrib_pkg::OP_WRITE, 511, 511, 1023, 1023, 0, 255);
        send_cmd(rrib_pkg::OP_WRITE, 0, 0, 0, 0, FB_BYTES - 1, 0);
        send_cmd(rrib_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
        send_cmd(rrib_pkg::OP_READ, 511, 511, 1023, 1023, FB_BYTES - 1, 255);
        send_cmd(OP_UNUSED, 511, 511, 1023, 1023, FB_BYTES - 1, 255);
        send_cmd(OP_UNUSED, 0, 0, 0, 0, 0, 0);
        rect_invert(5, 5, 0, 7);
        rect_invert(5, 5, 7, 0);
        rect_invert(511, 0, 4, 4);
        rect_invert(0, 511, 4, 4);
        rect_invert(290, 120, 1023, 1023);
        rect_invert(292, 125, 512, 512);
        rect_invert(0, 0, 9, 3);
        send_cmd(rrib_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
        rect_invert(0, 0, 9, 3);
        send_cmd(rrib_pkg::OP_READ, 0, 0, 0, 0, 0, 0);

        // random phases, each under its own geometry
        base = items_sent;
        for (int p = 0; p < PHASES; p++) begin
            case (p / 4)
                0: begin
                    send_idle = 15;
                    recv_idle = 49;
                end
                1: begin
                    send_idle = 49;
                    recv_idle = 15;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            if (p < 8) begin
                set_geometry(phase_rot[p], phase_width[p], phase_height[p], phase_rb[p]);
            end else begin
                set_geometry(2'($urandom_range(0, 3)),
                             $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 511),
                             $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 1023),
                             $urandom_range(0, 63));
            end
            dx = (g_rot == rrib_pkg::ROT_0 || g_rot == rrib_pkg::ROT_180) ? g_height : g_width;
            dy = (g_rot == rrib_pkg::ROT_0 || g_rot == rrib_pkg::ROT_180) ? g_width : g_height;
            big_ok = (dx * dy <= 1024);

            // both memory corners of the display
            rect_invert(0, 0, 2, 2);
            rect_invert(dx > 2 ? dx - 2 : 0, dy > 2 ? dy - 2 : 0, 1023, 1023);

            // long receiver hold-off while commands keep coming
            if (p == 1 || p == 9)
                hold_requests++;

            phase_end = base + (p + 1) * (ITEMS - base) / PHASES;
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    r = $urandom_range(0, 15);
                    if (big_ok && r < 2) begin
                        x = $urandom_range(0, dx);
                        y = $urandom_range(0, dy);
                        w = $urandom_range(0, 1023);
                        h = $urandom_range(0, 1023);
                    end else if (r < 4) begin
                        x = $urandom_range(0, 511);
                        y = $urandom_range(0, 511);
                        w = $urandom_range(0, 4);
                        h = $urandom_range(0, 4);
                    end else begin
                        x = $urandom_range(0, 23);
                        y = $urandom_range(0, 23);
                        w = $urandom_range(0, 10);
                        h = $urandom_range(0, 10);
                    end
                    rect_invert(x, y, w, h);
                end else if (pick < 80) begin
                    send_cmd(rrib_pkg::OP_WRITE, $urandom_range(0, 511),
                             $urandom_range(0, 511), $urandom_range(0, 1023),
                             $urandom_range(0, 1023), $urandom_range(0, FB_BYTES - 1),
                             $urandom_range(0, 255));
                end else if (pick < 95) begin
                    send_cmd(rrib_pkg::OP_READ, $urandom_range(0, 511),
                             $urandom_range(0, 511), $urandom_range(0, 1023),
                             $urandom_range(0, 1023),
                             written_addrs[$urandom_range(0, written_addrs.size() - 1)],
                             $urandom_range(0, 255));
                end else begin
                    send_cmd(OP_UNUSED, $urandom_range(0, 511), $urandom_range(0, 511),
                             $urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(0, FB_BYTES - 1), $urandom_range(0, 255));
                end
            end
        end

        // let the last results come out, then a short quiet stretch
        drain();
        repeat (20) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
